// ===== rtl/zbgp_pkg.sv =====
// Shared constants and the group record type for the zero-byte group packer.
package zbgp_pkg;

   localparam int GROUP_BYTES_DEF = 8;
   localparam int MAX_GROUP_BYTES = 8;
   localparam int SLOT_W          = $clog2(MAX_GROUP_BYTES);
   localparam int COUNT_W         = $clog2(MAX_GROUP_BYTES + 1);
   localparam int QUEUE_DEPTH     = 2;

   // One finished group, handed from the gatherer to the emitter.
   typedef struct packed {
      logic [7:0]                          zero_map;
      logic [MAX_GROUP_BYTES-1:0][7:0]     bytes;
      logic [COUNT_W-1:0]                  nz_count;
      logic                                fill;
      logic [7:0]                          fill_byte;
      logic                                stream_end;
   } zbgp_group_type;

endpackage

// ===== rtl/zbgp_front.sv =====
// Gatherer: collects incoming bytes into a group and hands each closed group on.
module zbgp_front #(
   parameter int GROUP_BYTES = zbgp_pkg::GROUP_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     stream_end,
   output logic                     grp_push,
   output zbgp_pkg::zbgp_group_type grp_data
);
   import zbgp_pkg::*;

   localparam int IDX_W = $clog2(GROUP_BYTES);
   localparam int CNT_W = $clog2(GROUP_BYTES + 1);

   logic [GROUP_BYTES-1:0] map_ff, map_in, map_next;
   logic [CNT_W-1:0]       pos_ff, pos_in, pos_next;
   logic [CNT_W-1:0]       cnt_ff, cnt_in, cnt_next;
   logic [7:0]             store_ff [GROUP_BYTES];
   logic                   nonzero;
   logic                   complete;

   always_comb begin
      nonzero  = |data_byte;
      pos_next = pos_ff + 1'b1;
      cnt_next = cnt_ff + CNT_W'(nonzero);
      map_next = map_ff | (GROUP_BYTES'(nonzero) << pos_ff[IDX_W-1:0]);
      complete = stream_end || (pos_next == CNT_W'(GROUP_BYTES));
      grp_push = accept && complete;

      grp_data            = '0;
      grp_data.zero_map   = 8'(map_next);
      for (int i = 0; i < GROUP_BYTES; i++) begin
         // bypass the byte arriving now into its slot
         if (nonzero && (cnt_ff == CNT_W'(i))) begin
            grp_data.bytes[i] = data_byte;
         end else begin
            grp_data.bytes[i] = store_ff[i];
         end
      end
      grp_data.nz_count   = COUNT_W'(cnt_next);
      grp_data.fill       = stream_end && (pos_next != CNT_W'(GROUP_BYTES));
      grp_data.fill_byte  = 8'(GROUP_BYTES) - 8'(pos_next);
      grp_data.stream_end = stream_end;

      map_in = map_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (complete) begin
            map_in = '0;
            pos_in = '0;
            cnt_in = '0;
         end else begin
            map_in = map_next;
            pos_in = pos_next;
            cnt_in = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
         pos_ff <= '0;
         cnt_ff <= '0;
      end else begin
         map_ff <= map_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && nonzero) begin
         store_ff[cnt_ff[IDX_W-1:0]] <= data_byte;
      end
   end

endmodule

// ===== rtl/zbgp_queue.sv =====
// Short queue of closed groups between the gatherer and the emitter.
module zbgp_queue #(
   parameter int DEPTH = zbgp_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  zbgp_pkg::zbgp_group_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output zbgp_pkg::zbgp_group_type head
);
   import zbgp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   zbgp_group_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full       = (count_ff == CNT_W'(DEPTH));
      head_valid = (count_ff != '0);
      head       = entries_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/zbgp_back.sv =====
// Emitter: walks one group record and drives packed bytes into the output register.
module zbgp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  zbgp_pkg::zbgp_group_type head,
   output logic                     head_pop,
   input  logic                     out_pop,
   output logic                     out_valid,
   output logic [7:0]               out_byte,
   output logic                     out_run_last,
   output logic                     out_packet_last
);
   import zbgp_pkg::*;

   logic [COUNT_W-1:0] k_ff, k_in;
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff;
   logic               run_last_ff;
   logic               pkt_last_ff;
   logic               advance;
   logic [7:0]         sel_byte;
   logic               sel_last;
   logic [SLOT_W-1:0]  slot;

   always_comb begin
      advance = head_valid && (!valid_ff || out_pop);
      slot    = SLOT_W'(k_ff - 1'b1);

      // element 0 is the bitmap, then the nonzero bytes, then the fill byte
      priority if (k_ff == '0) begin
         sel_byte = head.zero_map;
         sel_last = !head.fill && (head.nz_count == '0);
      end else if (k_ff <= head.nz_count) begin
         sel_byte = head.bytes[slot];
         sel_last = !head.fill && (k_ff == head.nz_count);
      end else begin
         sel_byte = head.fill_byte;
         sel_last = 1'b1;
      end

      head_pop = advance && sel_last;

      k_in = k_ff;
      if (advance) begin
         k_in = sel_last ? '0 : k_ff + 1'b1;
      end
      valid_in = advance || (valid_ff && !out_pop);

      out_valid       = valid_ff;
      out_byte        = byte_ff;
      out_run_last    = run_last_ff;
      out_packet_last = pkt_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff     <= sel_byte;
         run_last_ff <= sel_last;
         pkt_last_ff <= sel_last && head.stream_end;
      end
   end

endmodule

// ===== rtl/zero_byte_group_packer_core.sv =====
// Top level of the zero-byte group packer: gatherer, group queue and emitter.
//
//   channel   ports                                            direction
//   request   req_push, req_full, req_data_byte,
//             req_stream_end                                  in (queue write side)
//   result    rsp_empty, rsp_pop, rsp_out_byte,
//             rsp_run_last, rsp_packet_last                   out (queue read side)
//
// Each request byte is taken while req_full is low; a byte that closes a group (group
// full or stream_end) writes a group record into a two-entry queue that cycle.
// The emitter sends one packed byte per cycle from the queue head unless rsp_pop
// stalls it: bitmap, the nonzero bytes, then a fill byte when the stream ends short,
// at most GROUP_BYTES+1 results a group. Under steady pop the emitter sets the pace:
// GROUP_BYTES+1 results per full nonzero group, up to three for a one-byte stream.
// The closing byte writes its group record into the queue; once it is at the head,
// the emitter registers the record's first result in its output register.
// req_full is high while the group queue holds two records; rsp_pop low stalls
// only the emitter, the gatherer keeps filling until the queue is full.
// Synchronous active-high reset empties queue and output, clears the group.
module zero_byte_group_packer_core #(
   parameter int GROUP_BYTES = zbgp_pkg::GROUP_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_stream_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_packet_last
);
   import zbgp_pkg::*;

   logic           req_accept;
   logic           grp_push;
   zbgp_group_type grp_data;
   logic           q_full;
   logic           q_head_valid;
   zbgp_group_type q_head;
   logic           q_pop;
   logic           out_valid;

   // request taken whenever the queue has room for a possible closing byte
   assign req_full   = q_full;
   assign req_accept = req_push && !q_full;
   assign rsp_empty  = !out_valid;

   zbgp_front #(
      .GROUP_BYTES(GROUP_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .data_byte  (req_data_byte),
      .stream_end (req_stream_end),
      .grp_push   (grp_push),
      .grp_data   (grp_data)
   );

   zbgp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grp_push),
      .push_data  (grp_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // emitter holds one result in its output register; pop frees it same cycle
   zbgp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head            (q_head),
      .head_pop        (q_pop),
      .out_pop         (rsp_pop),
      .out_valid       (out_valid),
      .out_byte        (rsp_out_byte),
      .out_run_last    (rsp_run_last),
      .out_packet_last (rsp_packet_last)
   );

endmodule

// ===== rtl/zbgp_checker.sv =====
// Port-level checker for the zero-byte group packer, bound to the top level.
module zbgp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_packet_last
);

   // reset leaves nothing to read and room to write
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   // the queue only fills on a taken request
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!req_full && !req_push) |=> !req_full)
      else $error("request side went full with no request");

   // end of stream is always the end of a group's results
   a_pkt_implies_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_packet_last) |-> rsp_run_last)
      else $error("packet_last without run_last");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_run_last)
          && $stable(rsp_packet_last)))
      else $error("stalled result changed");

endmodule

bind zero_byte_group_packer_core zbgp_checker u_zbgp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_run_last    (rsp_run_last),
   .rsp_packet_last (rsp_packet_last)
);

// ===== tb/sv/zero_byte_group_packer_core_tb.sv =====
// Self-checking testbench for the zero-byte group packer core.
module zero_byte_group_packer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GROUP       = zbgp_pkg::GROUP_BYTES_DEF;
   localparam int CYCLE_LIMIT = 200000;   // well above the slowest legal run
   localparam int DRAIN       = 16;       // quiet cycles after the last packed byte
   localparam int TARGET      = 430;      // requests to send in total

   // One packed byte as the result port should present it.
   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       packet_last;
   } pack_out_type;

   // Tracks the group being gathered and the packed bytes still owed.
   class pack_tracker_type;
      logic [7:0]   zero_map;
      logic [7:0]   nz_bytes [GROUP];
      int           position;
      int           nz_count;
      pack_out_type bytes_due [$];
      int           errors;
      int           checked;
      int           groups;
      int           fills;

      function new();
         zero_map = 8'h00;
         position = 0;
         nz_count = 0;
         errors   = 0;
         checked  = 0;
         groups   = 0;
         fills    = 0;
      endfunction

      function void owe(logic [7:0] b, logic rl, logic pl);
         pack_out_type p;
         p.out_byte    = b;
         p.run_last    = rl;
         p.packet_last = pl;
         bytes_due.push_back(p);
      endfunction

      // Accepted request: gather it, and emit the group when it closes.
      function void take_byte(logic [7:0] data, logic last);
         bit fill;
         bit tail;
         if (data != 8'h00) begin
            zero_map[position] = 1'b1;
            nz_bytes[nz_count] = data;
            nz_count++;
         end
         position++;
         if (position < GROUP && !last)
            return;
         fill = last && (position < GROUP);
         owe(zero_map, !fill && nz_count == 0, last && !fill && nz_count == 0);
         for (int k = 0; k < nz_count; k++) begin
            tail = !fill && (k + 1 == nz_count);
            owe(nz_bytes[k], tail, last && tail);
         end
         if (fill) begin
            owe(8'(GROUP - position), 1'b1, 1'b1);
            fills++;
         end
         groups++;
         zero_map = 8'h00;
         position = 0;
         nz_count = 0;
      endfunction

      function void check_packed(logic [7:0] ob, logic rl, logic pl);
         pack_out_type d;
         if (bytes_due.size() == 0) begin
            $error("unexpected packed byte out_byte=%02h run_last=%0b packet_last=%0b",
                   ob, rl, pl);
            errors++;
            return;
         end
         d = bytes_due.pop_front();
         checked++;
         if (ob !== d.out_byte) begin
            $error("out_byte: expected %02h, got %02h", d.out_byte, ob);
            errors++;
         end
         if (rl !== d.run_last) begin
            $error("run_last: expected %0b, got %0b", d.run_last, rl);
            errors++;
         end
         if (pl !== d.packet_last) begin
            $error("packet_last: expected %0b, got %0b", d.packet_last, pl);
            errors++;
         end
      endfunction

      function int pending();
         return bytes_due.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_stream_end = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_packet_last;

   pack_tracker_type tracker;
   int          cycle_count = 0;
   int          sent = 0;
   int          streams = 0;
   int          burst_left = 1;

   // receiver stall pattern state
   int          pop_mode = 0;
   int          mode_left = 40;
   logic [1:0]  tick = 2'd0;

   logic [7:0]  directed [$];

   zero_byte_group_packer_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_stream_end  (req_stream_end),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_packet_last (rsp_packet_last)
   );

   always #10 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Monitor: values read here are the ones the block saw at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            tracker.take_byte(req_data_byte, req_stream_end);
         if (rsp_pop && !rsp_empty)
            tracker.check_packed(rsp_out_byte, rsp_run_last, rsp_packet_last);
      end
   end

   // Receiver: switches between free flow, coin-flip, one-in-four and
   // rare pops so stalls land on every phase of an emission.
   always @(posedge clock) begin
      tick <= tick + 2'd1;
      if (mode_left == 0) begin
         pop_mode  <= $urandom_range(3);
         mode_left <= $urandom_range(150, 20);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (pop_mode)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= 1'($urandom_range(1));
         2: rsp_pop <= (tick == 2'd0);
         default: rsp_pop <= ($urandom_range(7) == 0);
      endcase
   end

   // Hold one request until the block takes it; push stays high on return.
   task automatic send_request(input logic [7:0] data, input logic last);
      req_push       <= 1'b1;
      req_data_byte  <= data;
      req_stream_end <= last;
      do @(posedge clock); while (req_full);
      sent++;
      if (last)
         streams++;
   endtask

   // Sender in bursts: after each burst, a random gap (sometimes none).
   task automatic push_byte(input logic [7:0] data, input logic last);
      int gap;
      send_request(data, last);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(24, 1);
      end
   endtask

   task automatic send_list(input logic [7:0] vals [$], input bit ends);
      for (int i = 0; i < vals.size(); i++)
         push_byte(vals[i], ends && (i == vals.size() - 1));
   endtask

   // Raw byte with a given chance of zero; edge values show up often.
   function automatic logic [7:0] pick_byte(int zero_pct);
      if ($urandom_range(99) < zero_pct)
         return 8'h00;
      case ($urandom_range(7))
         0: return 8'h01;
         1: return 8'hff;
         2: return 8'h80;
         default: return 8'($urandom_range(255, 1));
      endcase
   endfunction

   task automatic random_stream();
      int len;
      int zero_pct;
      case ($urandom_range(9))
         0, 1, 2: len = $urandom_range(GROUP - 1, 1);            // partial group only
         3, 4, 5: len = GROUP * $urandom_range(3, 1);            // ends on a full group
         default: len = $urandom_range(30, 1);
      endcase
      case ($urandom_range(4))
         0: zero_pct = 0;
         1: zero_pct = 100;
         2: zero_pct = 70;
         default: zero_pct = 35;
      endcase
      for (int i = 0; i < len; i++)
         push_byte(pick_byte(zero_pct), i == len - 1);
   endtask

   initial begin
      bit paused;
      paused  = 1'b0;
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lone zero byte ends the stream: empty bitmap, then fill of GROUP-1
      directed = {8'h00};
      send_list(directed, 1'b1);
      // lone 0xff ends the stream: bitmap, byte, fill
      directed = {8'hff};
      send_list(directed, 1'b1);
      // full group mid-stream, mixed zero and nonzero bytes
      directed = {8'h01, 8'h00, 8'h80, 8'h00, 8'h55, 8'haa, 8'h00, 8'h7f};
      send_list(directed, 1'b0);
      // stream ends on a full all-zero group: bitmap alone carries packet_last
      directed = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_list(directed, 1'b1);
      // partial group, one short, ending on a zero byte
      directed = {8'hff, 8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'h00};
      send_list(directed, 1'b1);

      while (sent < TARGET) begin
         random_stream();
         // once, drain completely before carrying on
         if (!paused && sent > TARGET / 2) begin
            paused = 1'b1;
            req_push <= 1'b0;
            // step one edge first so the monitor has seen the last request
            do @(posedge clock); while (tracker.pending() != 0);
         end
      end
      req_push <= 1'b0;

      do @(posedge clock); while (tracker.pending() != 0);
      repeat (DRAIN) @(posedge clock);

      $display("Sent %0d bytes in %0d streams; %0d groups packed, %0d with a fill byte,",
               sent, streams, tracker.groups, tracker.fills);
      $display("%0d packed bytes compared under random push gaps and pop stalls.",
               tracker.checked);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
